FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the hashed word lookup RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HWL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hashed_word_lookup: same-cycle check failed");

// next-cycle implication, checked outside reset
`define HWL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hashed_word_lookup: next-cycle check failed");

`endif

FILE: sv/hwl_pkg.sv
// ----------------------------------------------------------------------------
// hwl_pkg
// Widths, operation codes and the sdbm byte fold for the hashed word lookup.
// ----------------------------------------------------------------------------
package hwl_pkg;

    localparam int unsigned DEFAULT_DEPTH = 4096;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned BYTE_W  = 8;

    localparam int unsigned SDBM_SHIFT_LO = 6;
    localparam int unsigned SDBM_SHIFT_HI = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // h' = sext(byte) + (h << 6) + (h << 16) - h, modulo 2^64
    function automatic logic [HASH_W-1:0] sdbm_fold(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] sx;
        sx = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        return sx + (h << SDBM_SHIFT_LO) + (h << SDBM_SHIFT_HI) - h;
    endfunction

endpackage

FILE: sv/hashed_word_lookup.sv
// Hashed word lookup: a sorted table of 64-bit word hashes and a query port.
// One input channel (valid/stall) carries both kinds of transaction:
//   operation 0 writes entry_hash at entry_index (ignored past the table end);
//   operation 1 folds query_byte into a running sdbm hash; with query_last set
//   it searches the first entry_count entries for the first hash not below the
//   query, counts the run of equal hashes and returns one result transaction
//   (found, first_index, match_count; all zero on a miss), then clears the hash.
// entry_count is written through i_cfg_we / i_cfg_data and clamped to the
// table depth. The user must write it only while the block is idle; the block
// itself does not enforce this. Table writes and non-final bytes are accepted
// while the block is idle and return nothing. A final byte starts a search in
// which each probe and each run step is one table read with registered data.
// The input stalls while a search is running or waiting to finish; the result
// sits in an output register, so a stalled receiver blocks only the next search.
// Reset clears the running hash, entry_count and the output valid; table
// contents are undefined until written.
// ----------------------------------------------------------------------------
// hashed_word_lookup
// Top level: configuration register, table memory and search engine.
// ----------------------------------------------------------------------------
module hashed_word_lookup #(
    parameter int unsigned TABLE_DEPTH = hwl_pkg::DEFAULT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hwl_pkg::COUNT_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [hwl_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic [hwl_pkg::HASH_W-1:0]        i_entry_hash,
    input  logic signed [hwl_pkg::BYTE_W-1:0] i_query_byte,
    input  logic                              i_query_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic [hwl_pkg::INDEX_W-1:0]       o_first_index,
    output logic [hwl_pkg::COUNT_W-1:0]       o_match_count
);
    import hwl_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0] r_entry_count;
    logic [NW-1:0]      w_active_count;
    logic               w_wr_en;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [HASH_W-1:0]  w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // clamp the count to the table size
    assign w_active_count = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ?
                            NW'(TABLE_DEPTH) : NW'(r_entry_count);

    assign w_wr_en = i_in_valid && !o_in_stall && (i_operation == OP_WRITE) &&
                     (32'(i_entry_index) < 32'(TABLE_DEPTH));

    hwl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (i_entry_hash),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    hwl_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_query_byte   (i_query_byte),
        .i_query_last   (i_query_last),
        .i_active_count (w_active_count),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_first_index  (o_first_index),
        .o_match_count  (o_match_count)
    );

endmodule

FILE: sv/hwl_table.sv
// ----------------------------------------------------------------------------
// hwl_table
// Hash table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hwl_table #(
    parameter int unsigned TABLE_DEPTH = hwl_pkg::DEFAULT_DEPTH,
    localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [hwl_pkg::HASH_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [hwl_pkg::HASH_W-1:0]  o_rd_data
);
    import hwl_pkg::*;

    logic [HASH_W-1:0] r_mem [TABLE_DEPTH];
    logic [HASH_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/hwl_search.sv
// ----------------------------------------------------------------------------
// hwl_search
// Running sdbm hash, lower-bound binary search and duplicate run count over
// the hash table, with the result register on the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hwl_search #(
    parameter int unsigned TABLE_DEPTH = hwl_pkg::DEFAULT_DEPTH,
    localparam int unsigned AW = $clog2(TABLE_DEPTH),
    localparam int unsigned NW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic signed [hwl_pkg::BYTE_W-1:0] i_query_byte,
    input  logic                          i_query_last,
    input  logic [NW-1:0]                 i_active_count,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [hwl_pkg::HASH_W-1:0]    i_rd_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [hwl_pkg::INDEX_W-1:0]   o_first_index,
    output logic [hwl_pkg::COUNT_W-1:0]   o_match_count
);
    import hwl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PROBE,
        S_CHECK,
        S_RUN,
        S_RUN_WAIT,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [HASH_W-1:0]   r_query, n_query;
    logic [NW-1:0]       r_lo, n_lo;
    logic [NW-1:0]       r_he, n_he;
    logic [NW-1:0]       r_mid, n_mid;
    logic [NW-1:0]       r_pos, n_pos;
    logic [NW-1:0]       r_run, n_run;
    logic                r_hit, n_hit;
    logic                r_out_valid, n_out_valid;
    logic                r_found, n_found;
    logic [INDEX_W-1:0]  r_first_index, n_first_index;
    logic [COUNT_W-1:0]  r_match_count, n_match_count;

    logic                w_accept;
    logic [HASH_W-1:0]   w_fold;
    logic [NW:0]         w_sum;
    logic [NW-1:0]       w_mid;
    logic [NW:0]         w_next;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_fold   = sdbm_fold(r_hash, i_query_byte);
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_he} - {{NW{1'b0}}, 1'b1};
    assign w_mid    = w_sum[NW:1];
    assign w_next   = {1'b0, r_pos} + {1'b0, r_run};

    always_comb begin
        n_state       = r_state;
        n_hash        = r_hash;
        n_query       = r_query;
        n_lo          = r_lo;
        n_he          = r_he;
        n_mid         = r_mid;
        n_pos         = r_pos;
        n_run         = r_run;
        n_hit         = r_hit;
        n_found       = r_found;
        n_first_index = r_first_index;
        n_match_count = r_match_count;
        n_out_valid   = r_out_valid && i_out_stall;
        o_rd_en       = 1'b0;
        o_rd_addr     = AW'(r_pos);

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == OP_QUERY)) begin
                    if (i_query_last) begin
                        n_hash  = '0;
                        n_query = w_fold;
                        n_lo    = '0;
                        n_he    = i_active_count;
                        n_pos   = '0;
                        n_run   = '0;
                        n_hit   = 1'b0;
                        n_state = (i_active_count == '0) ? S_FINISH : S_SEARCH;
                    end else begin
                        n_hash = w_fold;
                    end
                end
            end
            S_SEARCH: begin
                o_rd_en = 1'b1;
                if (r_lo < r_he) begin
                    o_rd_addr = AW'(w_mid);
                    n_mid     = w_mid;
                    n_state   = S_PROBE;
                end else begin
                    // search done: fetch the candidate entry
                    o_rd_addr = AW'(r_pos);
                    n_state   = S_CHECK;
                end
            end
            S_PROBE: begin
                if (i_rd_data >= r_query) begin
                    n_pos = r_mid;
                    n_he  = r_mid;
                end else begin
                    n_lo = r_mid + NW'(1);
                end
                n_state = S_SEARCH;
            end
            S_CHECK: begin
                if (i_rd_data == r_query) begin
                    n_hit   = 1'b1;
                    n_run   = NW'(1);
                    n_state = S_RUN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RUN: begin
                if (w_next < {1'b0, i_active_count}) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_next);
                    n_state   = S_RUN_WAIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RUN_WAIT: begin
                if (i_rd_data == r_query) begin
                    n_run   = r_run + NW'(1);
                    n_state = S_RUN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output slot is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_found       = r_hit;
                    n_first_index = r_hit ? INDEX_W'(r_pos) : '0;
                    n_match_count = r_hit ? COUNT_W'(r_run) : '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_lo        <= '0;
            r_he        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_lo        <= n_lo;
            r_he        <= n_he;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_query       <= n_query;
        r_mid         <= n_mid;
        r_run         <= n_run;
        r_hit         <= n_hit;
        r_found       <= n_found;
        r_first_index <= n_first_index;
        r_match_count <= n_match_count;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_first_index = r_first_index;
    assign o_match_count = r_match_count;

    `HWL_ASSERT_IMPL(a_miss_is_zero, i_clk, i_rst_n, o_out_valid && !o_found, (o_first_index == '0) && (o_match_count == '0))
    `HWL_ASSERT_IMPL(a_hit_has_count, i_clk, i_rst_n, o_out_valid && o_found, o_match_count != '0)
    `HWL_ASSERT_IMPL(a_bounds_ordered, i_clk, i_rst_n, (r_state == S_SEARCH) || (r_state == S_PROBE), r_lo <= r_he)
    `HWL_ASSERT_NEXT(a_probe_follows, i_clk, i_rst_n, (r_state == S_SEARCH) && (r_lo < r_he), r_state == S_PROBE)

endmodule

FILE: tb/tb_hashed_word_lookup.sv
// ----------------------------------------------------------------------------
// tb_hashed_word_lookup
// Self-checking bench for the hashed word lookup: loads sorted and unsorted
// tables, probes oversized counts, streams query words byte by byte and
// compares each search transaction with a local lower-bound search over a
// mirrored table.
// ----------------------------------------------------------------------------
module tb_hashed_word_lookup;
    import hwl_pkg::*;

    localparam int unsigned DEPTH      = DEFAULT_DEPTH;
    localparam int unsigned MAX_COUNT  = (1 << COUNT_W) - 1;
    localparam int unsigned MAX_WORD   = 16;
    localparam int unsigned RUN_LEN    = 64;
    localparam int unsigned SORTED_LEN = 256;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] first_index;
        logic [COUNT_W-1:0] match_count;
    } t_lookup_result;

    typedef struct packed {
        logic [4:0]                       len;
        logic [MAX_WORD-1:0][BYTE_W-1:0] ch;
    } t_word;

    typedef logic [HASH_W-1:0] t_hash_q[$];

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_we      = 1'b0;
    logic [COUNT_W-1:0]         i_cfg_data    = '0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_stall;
    logic                       i_operation   = OP_WRITE;
    logic [INDEX_W-1:0]         i_entry_index = '0;
    logic [HASH_W-1:0]          i_entry_hash  = '0;
    logic signed [BYTE_W-1:0]   i_query_byte  = '0;
    logic                       i_query_last  = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall   = 1'b0;
    logic                       o_found;
    logic [INDEX_W-1:0]         o_first_index;
    logic [COUNT_W-1:0]         o_match_count;

    logic [HASH_W-1:0]  table_model [DEPTH];
    logic [HASH_W-1:0]  hash_state      = '0;
    logic [COUNT_W-1:0] entry_count_cfg = '0;
    t_lookup_result     expected_lookups[$];
    t_word              word_pool[$];
    int unsigned        send_idle_pct   = 0;
    int unsigned        recv_stall_pct  = 0;
    int unsigned        fail_count      = 0;
    int unsigned        noise_limit     = 1;

    hashed_word_lookup #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_entry_hash  (i_entry_hash),
        .i_query_byte  (i_query_byte),
        .i_query_last  (i_query_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_first_index (o_first_index),
        .o_match_count (o_match_count)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // sdbm step: h * 65599 equals (h << 6) + (h << 16) - h
    function automatic logic [HASH_W-1:0] fold_query_byte(logic [HASH_W-1:0] h,
                                                          logic [BYTE_W-1:0] b);
        return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b} + h * 64'd65599;
    endfunction

    function automatic logic [HASH_W-1:0] word_hash(t_word w);
        logic [HASH_W-1:0] h;
        h = '0;
        for (int i = 0; i < w.len; i++) h = fold_query_byte(h, w.ch[i]);
        return h;
    endfunction

    function automatic t_word random_word(int unsigned max_len);
        t_word w;
        w.len = 5'($urandom_range(1, max_len));
        for (int i = 0; i < MAX_WORD; i++) w.ch[i] = BYTE_W'($urandom_range(255));
        return w;
    endfunction

    function automatic t_word byte_word(logic [BYTE_W-1:0] b);
        t_word w;
        w = '0;
        w.len   = 1;
        w.ch[0] = b;
        return w;
    endfunction

    // lower bound over the active entries, then length of the equal run
    function automatic t_lookup_result predict_lookup(logic [HASH_W-1:0] q);
        t_lookup_result res;
        int n, lo, hi, mid, pos, run;
        res = '0;
        n = (entry_count_cfg > DEPTH) ? DEPTH : entry_count_cfg;
        if (n == 0) return res;
        lo  = 0;
        hi  = n - 1;
        pos = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (table_model[mid] >= q) begin
                pos = mid;
                hi  = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        if (table_model[pos] != q) return res;
        run = 1;
        while (pos + run < n && table_model[pos + run] == q) run++;
        res.found       = 1'b1;
        res.first_index = pos[INDEX_W-1:0];
        res.match_count = run[COUNT_W-1:0];
        return res;
    endfunction

    task automatic set_idle_mode(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 83; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default:       begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    // entered and left at a falling edge; valid stays high for a following item
    task automatic send_item(logic op, logic [INDEX_W-1:0] idx, logic [HASH_W-1:0] h,
                             logic [BYTE_W-1:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_entry_hash  <= h;
        i_query_byte  <= b;
        i_query_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_WRITE) begin
            table_model[idx] = h;
        end else begin
            hash_state = fold_query_byte(hash_state, b);
            if (last) begin
                expected_lookups.push_back(predict_lookup(hash_state));
                hash_state = '0;
            end
        end
        @(negedge i_clk);
    endtask

    task automatic write_entry(int unsigned idx, logic [HASH_W-1:0] h);
        send_item(OP_WRITE, idx[INDEX_W-1:0], h, BYTE_W'($urandom_range(255)),
                  1'($urandom_range(1)));
    endtask

    task automatic send_query_byte(logic [BYTE_W-1:0] b, logic last);
        send_item(OP_QUERY, INDEX_W'($urandom_range(DEPTH - 1)), {$urandom, $urandom},
                  b, last);
    endtask

    // mostly rewrite the stored value, sometimes scramble the entry
    task automatic noise_write();
        int unsigned idx;
        idx = $urandom_range(noise_limit - 1);
        if ($urandom_range(3) == 0) write_entry(idx, {$urandom, $urandom});
        else write_entry(idx, table_model[idx]);
    endtask

    task automatic send_word(t_word w, bit with_noise);
        for (int i = 0; i < w.len; i++) begin
            if (with_noise && $urandom_range(15) == 0) noise_write();
            send_query_byte(w.ch[i], i == w.len - 1);
        end
    endtask

    task automatic send_pool_or_random(int unsigned pool_pct);
        if ($urandom_range(99) < pool_pct)
            send_word(word_pool[$urandom_range(word_pool.size() - 1)], 1'b0);
        else
            send_word(random_word(MAX_WORD), 1'b0);
    endtask

    task automatic new_word_pool(int unsigned count);
        word_pool.delete();
        repeat (count) word_pool.push_back(random_word(8));
    endtask

    task automatic fill_hashes(int unsigned n, int unsigned pool_pct, output t_hash_q vals);
        vals.delete();
        repeat (n) begin
            if ($urandom_range(99) < pool_pct)
                vals.push_back(word_hash(word_pool[$urandom_range(word_pool.size() - 1)]));
            else
                vals.push_back({$urandom, $urandom});
        end
    endtask

    task automatic load_table(t_hash_q vals);
        foreach (vals[i]) write_entry(i, vals[i]);
    endtask

    // hold input until every search result is back, then let writes settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_entry_count(int unsigned value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we        <= 1'b0;
        entry_count_cfg  = value[COUNT_W-1:0];
    endtask

    task automatic test_empty_table();
        send_word(byte_word(8'h00), 1'b0);
        send_word(byte_word(8'h7f), 1'b0);
        send_word(byte_word(8'h80), 1'b0);
        send_word(byte_word(8'hff), 1'b0);
        set_entry_count(0);
        repeat (3) send_word(random_word(MAX_WORD), 1'b0);
    endtask

    task automatic test_directed_table();
        t_hash_q vals;
        t_word   ab;
        ab      = '0;
        ab.len  = 2;
        ab.ch[0] = 8'h61;
        ab.ch[1] = 8'h62;
        vals = '{64'd0, 64'd0, 64'd5, 64'd5, 64'd5, word_hash(ab),
                 64'hffff_ffff_ffff_ff80, 64'hffff_ffff_ffff_ffff};
        load_table(vals);
        set_entry_count(vals.size());
        send_word(byte_word(8'h00), 1'b0);
        send_word(byte_word(8'h05), 1'b0);
        // a table write between bytes must not disturb the running hash
        send_query_byte(8'h61, 1'b0);
        write_entry(5, table_model[5]);
        send_query_byte(8'h62, 1'b1);
        send_word(byte_word(8'h80), 1'b0);
        send_word(byte_word(8'hff), 1'b0);
        send_word(byte_word(8'h03), 1'b0);
        send_word(byte_word(8'h7f), 1'b0);
        // nothing at or above the query inside the active range
        set_entry_count(vals.size() - 1);
        send_word(byte_word(8'hff), 1'b0);
        // run of two cut off by the count
        set_entry_count(1);
        send_word(byte_word(8'h00), 1'b0);
    endtask

    task automatic test_unsorted_table();
        t_hash_q vals;
        set_idle_mode(IDLE_SENDER);
        new_word_pool(10);
        fill_hashes(24, 60, vals);
        load_table(vals);
        set_entry_count(24);
        repeat (40) send_pool_or_random(70);
        wait_idle();
    endtask

    task automatic test_count_limit();
        logic [HASH_W-1:0] h;
        int unsigned       lo, hi, mid;
        set_idle_mode(IDLE_BOTH);
        h = word_hash(byte_word(8'h41));
        for (int i = 0; i < RUN_LEN; i++) write_entry(i, h);
        set_entry_count(RUN_LEN);
        send_word(byte_word(8'h41), 1'b0);
        send_word(byte_word(8'h42), 1'b0);
        send_word(byte_word(8'h00), 1'b0);
        set_entry_count(RUN_LEN / 2);
        send_word(byte_word(8'h41), 1'b0);
        // oversized counts act as the whole table: fill only the entries that
        // a search climbing to the last entry probes, last one matching
        lo = 0;
        hi = DEPTH - 1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            write_entry(mid, '0);
            lo = mid + 1;
        end
        write_entry(DEPTH - 1, h);
        set_entry_count(DEPTH);
        send_word(byte_word(8'h41), 1'b0);
        send_word(byte_word(8'h7f), 1'b0);
        set_entry_count(MAX_COUNT);
        send_word(byte_word(8'h41), 1'b0);
        set_entry_count(DEPTH + 1);
        send_word(byte_word(8'h41), 1'b0);
        send_word(byte_word(8'h7f), 1'b0);
        wait_idle();
    endtask

    task automatic test_sorted_table();
        t_hash_q vals;
        set_idle_mode(IDLE_NONE);
        new_word_pool(40);
        fill_hashes(SORTED_LEN - 1, 50, vals);
        vals.push_back('1);
        vals.sort();
        load_table(vals);
        set_entry_count(SORTED_LEN);
        send_word(byte_word(8'hff), 1'b0);
        send_word(byte_word(8'h00), 1'b0);
        repeat (30) send_pool_or_random(80);
        set_entry_count(SORTED_LEN - 1);
        send_word(byte_word(8'hff), 1'b0);
        repeat (10) send_pool_or_random(80);
        set_entry_count(SORTED_LEN / 3);
        repeat (10) send_pool_or_random(80);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        t_hash_q     vals;
        int unsigned n, budget, pick;
        t_word       w;
        for (int phase = 0; phase < 16; phase++) begin
            set_idle_mode(t_idle_mode'(phase % 4));
            new_word_pool(12);
            n = ($urandom_range(7) != 0) ? $urandom_range(1, 32) : $urandom_range(33, 160);
            fill_hashes(n, 70, vals);
            vals.sort();
            load_table(vals);
            noise_limit = n;
            case ($urandom_range(15))
                0:       set_entry_count(0);
                1:       set_entry_count($urandom_range(n));
                default: set_entry_count(n);
            endcase
            budget = 0;
            while (budget < 40) begin
                pick = $urandom_range(99);
                if (pick < 90) begin
                    w = (pick < 60) ? word_pool[$urandom_range(word_pool.size() - 1)]
                                    : random_word(MAX_WORD);
                    send_word(w, 1'b1);
                    budget += w.len;
                end else begin
                    noise_write();
                    budget++;
                end
            end
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lookups.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transaction: found=%0d first=%0d count=%0d",
                             o_found, o_first_index, o_match_count);
            end else begin
                want = expected_lookups.pop_front();
                if (o_found !== want.found || o_first_index !== want.first_index ||
                    o_match_count !== want.match_count) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected found=%0d first=%0d count=%0d, %s%0d %s%0d %s%0d",
                                 want.found, want.first_index, want.match_count,
                                 "got found=", o_found, "first=", o_first_index,
                                 "count=", o_match_count);
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("hashed_word_lookup verification failed");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idle_mode(IDLE_NONE);
        test_empty_table();
        test_directed_table();
        test_unsorted_table();
        test_count_limit();
        test_sorted_table();
        test_random_traffic();
        wait_idle();
        repeat (16) @(negedge i_clk);
        if (expected_lookups.size() != 0) begin
            fail_count += expected_lookups.size();
            $display("%0d result transactions never arrived", expected_lookups.size());
        end
        if (fail_count == 0)
            $display("hashed_word_lookup verification clean");
        else
            $display("hashed_word_lookup verification failed");
        $finish;
    end

endmodule
